// ===== rtl/core/wfpd_pkg.sv =====
// Shared constants, register indexes and control types for the wall-following PD controller.
package wfpd_pkg;

  localparam int ADC_BITS       = 12;
  localparam int DIST_FRAC_BITS = 8;

  localparam int ADC_FS   = (1 << ADC_BITS) - 1;
  localparam int SCALE_MUL = 300;
  localparam int OFFSET_C = 42 * ADC_FS;
  // 300 < 2^9, so 300*adc fits in ADC_BITS+9 bits
  localparam int DEN_W    = ADC_BITS + 9;

  localparam logic [63:0] DIST_NUM    = 64'(1000 * ADC_FS) << DIST_FRAC_BITS;
  localparam logic [63:0] DIST_NUM_HI = DIST_NUM >> 16;
  localparam logic [15:0] DIST_NEAR   = 16'(35 << DIST_FRAC_BITS);

  localparam int DUTY_W = 16;
  localparam int DIST_W = 16;
  // 21-bit signed gain times 17-bit signed difference, sum of two such products
  localparam int ACC_W  = 38;
  localparam int CHG_W  = ACC_W - DIST_FRAC_BITS;
  localparam int SUM_W  = CHG_W + 1;

  localparam int IN_W   = 56;
  localparam int OUT_W  = 56;

  localparam logic [2:0] CFG_TARGET_WALL = 3'd0;
  localparam logic [2:0] CFG_PROP_GAIN   = 3'd1;
  localparam logic [2:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] CFG_DUTY_HIGH   = 3'd3;
  localparam logic [2:0] CFG_DUTY_LOW    = 3'd4;
  localparam logic [2:0] CFG_DUTY_INIT   = 3'd5;
  localparam logic [2:0] CFG_FALLOFF     = 3'd6;

  localparam logic [1:0] EXIT_FRONT = 2'd0;
  localparam logic [1:0] EXIT_TICKS = 2'd1;
  localparam logic [1:0] EXIT_WALL  = 2'd2;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic mul_p;
    logic mul_d;
    logic sum;
    logic rnd;
    logic clamp;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/wfpd_div.sv =====
// Sensor reading to distance: reciprocal law by restoring division, one quotient bit a cycle.
module wfpd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wfpd_pkg::ADC_BITS-1:0] adc,
  output logic                         busy,
  output logic [wfpd_pkg::DIST_W-1:0]  distance
);
  import wfpd_pkg::*;

  logic [DEN_W-1:0] pos;
  logic [DEN_W-1:0] den_in;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic [3:0]       cnt;

  assign pos    = DEN_W'(SCALE_MUL) * DEN_W'(adc);
  assign den_in = pos - DEN_W'(OFFSET_C);
  assign trial  = {rem, DIST_NUM[cnt]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      if (pos <= DEN_W'(OFFSET_C)) begin
        busy     <= 1'b0;
        distance <= DIST_NEAR;
      end else if (den_in <= DEN_W'(DIST_NUM_HI)) begin
        // quotient would not fit 16 bits
        busy     <= 1'b0;
        distance <= '1;
      end else begin
        busy     <= 1'b1;
        den      <= den_in;
        rem      <= DEN_W'(DIST_NUM_HI);
        cnt      <= 4'd15;
        distance <= '0;
      end
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem      <= DEN_W'(trial - {1'b0, den});
        distance <= {distance[DIST_W-2:0], 1'b1};
      end else begin
        rem      <= trial[DEN_W-1:0];
        distance <= {distance[DIST_W-2:0], 1'b0};
      end
      cnt <= cnt - 4'd1;
      if (cnt == 4'd0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/wfpd_datapath.sv =====
// Datapath: config registers, input capture, distance dividers, PD arithmetic, result register.
module wfpd_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [2:0]                   cfg_index,
  input  logic [19:0]                  cfg_data,
  input  logic [wfpd_pkg::IN_W-1:0]    s_tdata,
  input  logic                         m_tready,
  output logic                         m_tvalid,
  output logic [wfpd_pkg::OUT_W-1:0]   m_tdata,
  input  wfpd_pkg::cmd_t               cmd,
  output wfpd_pkg::status_t            stat
);
  import wfpd_pkg::*;

  // configuration
  logic [15:0] target_wall;
  logic [15:0] prop_gain;
  logic [19:0] deriv_gain;
  logic [15:0] duty_high;
  logic [15:0] duty_low;
  logic [15:0] duty_init;
  logic [15:0] falloff_distance;

  // segment state
  logic [15:0] right_level;
  logic [15:0] left_level;
  logic [15:0] last_distance;
  logic [15:0] tick_total;
  logic [1:0]  segment_mode;
  logic [15:0] segment_limit;

  // captured request
  logic [1:0]          exit_mode;
  logic [15:0]         exit_limit;
  logic [ADC_BITS-1:0] left_adc;
  logic [ADC_BITS-1:0] front_adc;
  logic [7:0]          left_ticks;
  logic                op;

  logic [DIST_W-1:0] dl;
  logic [DIST_W-1:0] df;
  logic              busy_l;
  logic              busy_f;

  logic signed [20:0]      mul_a;
  logic signed [16:0]      mul_b;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [CHG_W-1:0] chg;
  logic [15:0]             res_right;
  logic [15:0]             res_left;
  logic [16:0]             tick_wide;
  logic [15:0]             tick_sum;
  logic                    done;

  function automatic logic [15:0] clamp_duty(input logic signed [SUM_W-1:0] v,
                                             input logic [15:0] hi,
                                             input logic [15:0] lo);
    logic signed [SUM_W-1:0] r;
    r = v;
    if (r > $signed({{(SUM_W-16){1'b0}}, hi})) begin
      r = $signed({{(SUM_W-16){1'b0}}, hi});
    end
    if (r < $signed({{(SUM_W-16){1'b0}}, lo})) begin
      r = $signed({{(SUM_W-16){1'b0}}, lo});
    end
    return r[15:0];
  endfunction

  wfpd_div u_div_left (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .adc      (left_adc),
    .busy     (busy_l),
    .distance (dl)
  );

  wfpd_div u_div_front (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .adc      (front_adc),
    .busy     (busy_f),
    .distance (df)
  );

  assign stat.div_busy = busy_l | busy_f;
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_wall      <= 16'd3072;
      prop_gain        <= 16'd2600;
      deriv_gain       <= 20'd75000;
      duty_high        <= 16'd42000;
      duty_low         <= 16'd20000;
      duty_init        <= 16'd20000;
      falloff_distance <= 16'd6400;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TARGET_WALL: target_wall      <= cfg_data[15:0];
        CFG_PROP_GAIN:   prop_gain        <= cfg_data[15:0];
        CFG_DERIV_GAIN:  deriv_gain       <= cfg_data;
        CFG_DUTY_HIGH:   duty_high        <= cfg_data[15:0];
        CFG_DUTY_LOW:    duty_low         <= cfg_data[15:0];
        CFG_DUTY_INIT:   duty_init        <= cfg_data[15:0];
        CFG_FALLOFF:     falloff_distance <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op         <= s_tdata[IN_W-1];
      exit_mode  <= s_tdata[1:0];
      exit_limit <= s_tdata[17:2];
      left_adc   <= s_tdata[29:18];
      front_adc  <= s_tdata[41:30];
      left_ticks <= s_tdata[49:42];
    end
  end

  // shared multiplier: proportional term first, derivative term second
  always_comb begin
    if (cmd.mul_p) begin
      mul_a = $signed({5'd0, prop_gain});
      mul_b = $signed({1'b0, dl}) - $signed({1'b0, target_wall});
    end else begin
      mul_a = $signed({1'b0, deriv_gain});
      mul_b = $signed({1'b0, dl}) - $signed({1'b0, last_distance});
    end
  end

  // truncate toward zero
  assign acc_rnd = acc[ACC_W-1] ? acc + ACC_W'((1 << DIST_FRAC_BITS) - 1) : acc;

  always_ff @(posedge clk) begin
    if (cmd.mul_p || cmd.mul_d) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.mul_d) begin
      acc <= prod;
    end
    if (cmd.sum) begin
      acc <= acc + prod;
    end
    if (cmd.rnd) begin
      chg <= CHG_W'(acc_rnd >>> DIST_FRAC_BITS);
    end
    if (cmd.clamp) begin
      res_right <= clamp_duty($signed({{(SUM_W-16){1'b0}}, right_level}) + SUM_W'(chg),
                              duty_high, duty_low);
      res_left  <= clamp_duty($signed({{(SUM_W-16){1'b0}}, left_level}) - SUM_W'(chg),
                              duty_high, duty_low);
    end
  end

  assign tick_wide = {1'b0, tick_total} + {9'd0, left_ticks};
  assign tick_sum  = tick_wide[16] ? 16'hFFFF : tick_wide[15:0];

  always_comb begin
    case (segment_mode)
      EXIT_FRONT: done = (df <= segment_limit);
      EXIT_TICKS: done = (tick_sum >= segment_limit);
      EXIT_WALL:  done = (dl >= falloff_distance);
      default:    done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_level   <= 16'd20000;
      left_level    <= 16'd20000;
      last_distance <= 16'd3072;
      tick_total    <= '0;
      segment_mode  <= '0;
      segment_limit <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // a write only comes when the output register is free
      if (cmd.write) begin
        m_tvalid <= 1'b1;
        if (op == OP_START) begin
          right_level   <= duty_init;
          left_level    <= duty_init;
          last_distance <= target_wall;
          tick_total    <= '0;
          segment_mode  <= exit_mode;
          segment_limit <= exit_limit;
          m_tdata       <= {7'd0, 1'b0, 16'd0, duty_init, duty_init};
        end else begin
          right_level   <= res_right;
          left_level    <= res_left;
          last_distance <= dl;
          tick_total    <= tick_sum;
          m_tdata       <= {7'd0, done, dl, res_left, res_right};
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/wfpd_ctrl.sv =====
// Sequencer: steps a sample through division, multiply, round, clamp and result write; a start only writes.
module wfpd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_op,
  output logic              s_tready,
  input  wfpd_pkg::status_t stat,
  output wfpd_pkg::cmd_t    cmd
);
  import wfpd_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_MULP  = 4'd3;
  localparam logic [3:0] ST_MULD  = 4'd4;
  localparam logic [3:0] ST_SUM   = 4'd5;
  localparam logic [3:0] ST_RND   = 4'd6;
  localparam logic [3:0] ST_CLAMP = 4'd7;
  localparam logic [3:0] ST_WRITE = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = (s_op == OP_START) ? ST_WRITE : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_next = ST_MULP;
        end
      end
      ST_MULP: begin
        cmd.mul_p  = 1'b1;
        state_next = ST_MULD;
      end
      ST_MULD: begin
        cmd.mul_d  = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_RND;
      end
      ST_RND: begin
        cmd.rnd    = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (stat.out_free) begin
          cmd.write  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/wall_follow_pd_controller.sv =====
// Top level of the wall-following PD controller.
// One request per control period on the s_ channel: s_tuser is the op (0 start, 1 sample),
// s_tdata carries the exit selection and the raw sensor and encoder readings.
// One result per request on the m_ channel: both wheel duties, left distance, done flag.
// Configuration registers are written on the cfg_ channel (always ready), only while idle:
// the user is bound to that, the block itself does not enforce it. A sample runs from
// acceptance to result through a divider load, restoring division of the two distances
// (both sensors in parallel), a wait to see the dividers finish, then the shared
// multiplier twice, add, round, clamp and the result write. When neither reading needs a
// division (near floor or saturated), the dividers are done at once. A start request goes
// straight from acceptance to the result write. One request is in work at a time; s_tready
// is high only while the sequencer is idle, so a request holds the input until its result is written.
// A result waits in the output register while m_tready is low; the next request can
// be taken and worked on meanwhile and then holds in the write step until it frees.
// Reset loads the default registers, both levels to 20000, the remembered distance
// to 3072, clears the tick total and drops m_tvalid.
module wall_follow_pd_controller (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // exit_mode[1:0], exit_limit[17:2], left_adc[29:18], front_adc[41:30],
  // left_ticks[49:42], zero fill
  input  logic [wfpd_pkg::IN_W-1:0]  s_tdata,
  // op
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // right_duty[15:0], left_duty[31:16], left_distance[47:32], done_res[48], zero fill
  output logic [wfpd_pkg::OUT_W-1:0] m_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [19:0]                cfg_data
);
  import wfpd_pkg::*;

  cmd_t               cmd;
  status_t            stat;
  logic [IN_W-1:0]    req_data;

  assign cfg_ready = 1'b1;
  // op rides in the top bit of the captured word
  assign req_data  = {s_tuser, s_tdata[IN_W-2:0]};

  wfpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_op     (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wfpd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (req_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef SYNTHESIS
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in work");

  a_start_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[47:32] == 16'd0) |->
      (m_tdata[15:0] == m_tdata[31:16] && !m_tdata[48]))
    else $error("start result with unequal duties or done set");

  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");
`endif

endmodule

// ===== test/wall_follow_pd_controller_test.sv =====
// Self-checking testbench for the wall-following PD controller: random bursts, stalls, checks.
module wall_follow_pd_controller_test;
  import wfpd_pkg::*;

  localparam logic [1:0] EXIT_NONE = 2'd3;    // unused exit mode, never done
  localparam int FULL_SCALE = (1 << ADC_BITS) - 1;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RX_OPEN = 0;
  localparam int RX_CHOPPY = 1;
  localparam int RX_HELD = 2;

  typedef struct {
    logic [15:0] right;
    logic [15:0] left;
    logic [15:0] range;
    logic        done;
  } drive_result_t;

  class duty_scoreboard;
    logic [15:0] wall_goal, kp, duty_ceil, duty_floor, duty_start, wall_end;
    logic [19:0] kd;
    logic [15:0] right_now, left_now, prev_range, ticks_run, exit_bound;
    logic [1:0]  exit_sel;
    drive_result_t expected_drives[$];
    int failures;

    function new();
      wall_goal  = 16'd3072;
      kp         = 16'd2600;
      kd         = 20'd75000;
      duty_ceil  = 16'd42000;
      duty_floor = 16'd20000;
      duty_start = 16'd20000;
      wall_end   = 16'd6400;
      right_now  = duty_start;
      left_now   = duty_start;
      prev_range = wall_goal;
      ticks_run  = '0;
      exit_sel   = EXIT_FRONT;
      exit_bound = '0;
      failures   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [19:0] val);
      case (idx)
        CFG_TARGET_WALL: wall_goal = val[15:0];
        CFG_PROP_GAIN:   kp = val[15:0];
        CFG_DERIV_GAIN:  kd = val;
        CFG_DUTY_HIGH:   duty_ceil = val[15:0];
        CFG_DUTY_LOW:    duty_floor = val[15:0];
        CFG_DUTY_INIT:   duty_start = val[15:0];
        CFG_FALLOFF:     wall_end = val[15:0];
        default: ;
      endcase
    endfunction

    // reciprocal sensor law, 1/256 cm, saturating
    function logic [15:0] sensor_range(logic [11:0] adc);
      longint scaled, offset, quot;
      scaled = longint'(adc) * 300;
      offset = 42 * longint'(FULL_SCALE);
      if (scaled <= offset) return 16'(35 << DIST_FRAC_BITS);
      quot = ((1000 * longint'(FULL_SCALE)) << DIST_FRAC_BITS) / (scaled - offset);
      return (quot > 65535) ? 16'hFFFF : quot[15:0];
    endfunction

    function logic [15:0] clamp_level(longint v);
      if (v > longint'(duty_ceil)) v = longint'(duty_ceil);
      if (v < longint'(duty_floor)) v = longint'(duty_floor);
      return v[15:0];
    endfunction

    function drive_result_t predict_period(logic op, logic [IN_W-1:0] d);
      drive_result_t r;
      logic [15:0] front_range;
      longint pd_sum, change;
      int ticks_sum;
      if (op == OP_START) begin
        right_now  = duty_start;
        left_now   = duty_start;
        prev_range = wall_goal;
        ticks_run  = '0;
        exit_sel   = d[1:0];
        exit_bound = d[17:2];
        r.right = duty_start;
        r.left  = duty_start;
        r.range = '0;
        r.done  = 1'b0;
        return r;
      end
      r.range     = sensor_range(d[29:18]);
      front_range = sensor_range(d[41:30]);
      pd_sum = longint'(kp) * (longint'(r.range) - longint'(wall_goal))
             + longint'(kd) * (longint'(r.range) - longint'(prev_range));
      change = pd_sum / (longint'(1) << DIST_FRAC_BITS);
      prev_range = r.range;
      right_now = clamp_level(longint'(right_now) + change);
      left_now  = clamp_level(longint'(left_now) - change);
      ticks_sum = int'(ticks_run) + int'(d[49:42]);
      ticks_run = (ticks_sum > 65535) ? 16'hFFFF : ticks_sum[15:0];
      case (exit_sel)
        EXIT_FRONT: r.done = (front_range <= exit_bound);
        EXIT_TICKS: r.done = (ticks_run >= exit_bound);
        EXIT_WALL:  r.done = (r.range >= wall_end);
        default:    r.done = 1'b0;
      endcase
      r.right = right_now;
      r.left  = left_now;
      return r;
    endfunction

    function void note_request(logic op, logic [IN_W-1:0] d);
      expected_drives.push_back(predict_period(op, d));
    endfunction

    function void flag_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v === act_v) return;
      failures++;
      if (failures <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, exp_v, act_v);
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      drive_result_t e;
      if (expected_drives.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result with no request outstanding: %h", d);
        return;
      end
      e = expected_drives.pop_front();
      flag_field("right_duty", e.right, d[15:0]);
      flag_field("left_duty", e.left, d[31:16]);
      flag_field("left_distance", e.range, d[47:32]);
      flag_field("done_res", 16'(e.done), 16'(d[48]));
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [19:0] cfg_data;

  duty_scoreboard sb;
  int burst_left = 0;
  int rx_left = 0;
  int rx_kind = RX_OPEN;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wall_follow_pd_controller uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // results are checked before the request taken on the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // receiver: open, choppy and held stretches
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_kind = int'($urandom_range(RX_OPEN, RX_HELD));
      rx_left = (rx_kind == RX_HELD) ? int'($urandom_range(1, 30))
                                     : int'($urandom_range(10, 60));
    end
    rx_left--;
    case (rx_kind)
      RX_OPEN:   m_tready = 1'b1;
      RX_CHOPPY: m_tready = 1'($urandom_range(0, 1));
      default:   m_tready = 1'b0;
    endcase
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("wall_follow_pd_controller_test: FAIL");
    $finish;
  end

  task automatic send_request(input logic op, input logic [1:0] mode, input logic [15:0] bound,
                              input logic [11:0] left_adc, input logic [11:0] front_adc,
                              input logic [7:0] ticks);
    s_tuser  = op;
    s_tdata  = {6'b0, ticks, front_adc, left_adc, bound, mode};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // sender bursts with random gaps
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = int'($urandom_range(1, 40));
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 30));
      if (gap != 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(input logic [15:0] goal, input logic [15:0] p_gain,
                           input logic [19:0] d_gain, input logic [15:0] ceil_v,
                           input logic [15:0] floor_v, input logic [15:0] start_v,
                           input logic [15:0] end_v);
    write_reg(CFG_TARGET_WALL, 20'(goal));
    write_reg(CFG_PROP_GAIN, 20'(p_gain));
    write_reg(CFG_DERIV_GAIN, d_gain);
    write_reg(CFG_DUTY_HIGH, 20'(ceil_v));
    write_reg(CFG_DUTY_LOW, 20'(floor_v));
    write_reg(CFG_DUTY_INIT, 20'(start_v));
    write_reg(CFG_FALLOFF, 20'(end_v));
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // readings spread over the near floor, the saturation edge and the far range
  function automatic logic [11:0] pick_adc();
    case ($urandom_range(0, 5))
      0: return 12'($urandom_range(0, FULL_SCALE));
      1: return 12'($urandom_range(0, 573));
      2: return 12'($urandom_range(570, 700));
      3: return 12'($urandom_range(700, 1500));
      4: return 12'($urandom_range(1500, FULL_SCALE));
      default: begin
        case ($urandom_range(0, 3))
          0: return 12'd0;
          1: return 12'd573;
          2: return 12'd574;
          default: return 12'(FULL_SCALE);
        endcase
      end
    endcase
  endfunction

  task automatic run_segments(input int count);
    int sent, run, pick;
    logic [1:0] mode;
    logic [15:0] bound;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 7) == 0) begin
        // noise: requests with every field random
        repeat ($urandom_range(1, 8)) begin
          send_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       16'($urandom_range(0, 65535)),
                       12'($urandom_range(0, FULL_SCALE)), 12'($urandom_range(0, FULL_SCALE)),
                       8'($urandom_range(0, 255)));
          pace();
          sent++;
        end
      end else begin
        pick = int'($urandom_range(0, 9));
        mode = (pick < 3) ? EXIT_FRONT : (pick < 6) ? EXIT_TICKS :
               (pick < 9) ? EXIT_WALL : EXIT_NONE;
        if ($urandom_range(0, 1) == 0) bound = 16'($urandom_range(0, 65535));
        else if (mode == EXIT_TICKS) bound = 16'($urandom_range(0, 3000));
        else bound = 16'($urandom_range(2000, 12000));
        send_request(OP_START, mode, bound, 12'($urandom_range(0, FULL_SCALE)),
                     12'($urandom_range(0, FULL_SCALE)), 8'($urandom_range(0, 255)));
        pace();
        sent++;
        run = int'($urandom_range(2, 25));
        repeat (run) begin
          send_request(OP_SAMPLE, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                       pick_adc(), pick_adc(), 8'($urandom_range(0, 255)));
          pace();
          sent++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = OP_START;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TARGET_WALL;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // sample straight after reset: front exit with a zero bound
    send_request(OP_SAMPLE, EXIT_FRONT, 16'd0, 12'd2000, 12'd2000, 8'd5);
    send_request(OP_START, EXIT_FRONT, 16'hFFFF, 12'hFFF, 12'hFFF, 8'hFF);
    send_request(OP_SAMPLE, EXIT_FRONT, 16'd0, 12'd0, 12'd0, 8'd0);
    send_request(OP_SAMPLE, EXIT_FRONT, 16'd0, 12'd573, 12'd574, 8'd1);
    send_request(OP_SAMPLE, EXIT_FRONT, 16'd0, 12'd574, 12'd573, 8'd2);
    send_request(OP_SAMPLE, EXIT_FRONT, 16'd0, 12'hFFF, 12'hFFF, 8'hFF);
    send_request(OP_SAMPLE, EXIT_FRONT, 16'd0, 12'd626, 12'd627, 8'd0);
    send_request(OP_START, EXIT_TICKS, 16'd300, 12'd0, 12'd0, 8'd0);
    send_request(OP_SAMPLE, EXIT_TICKS, 16'd0, 12'd900, 12'd900, 8'hFF);
    send_request(OP_SAMPLE, EXIT_TICKS, 16'd0, 12'd900, 12'd900, 8'hFF);
    send_request(OP_START, EXIT_TICKS, 16'd0, 12'd0, 12'd0, 8'd0);
    send_request(OP_SAMPLE, EXIT_TICKS, 16'd0, 12'd1200, 12'd1200, 8'd0);
    send_request(OP_START, EXIT_WALL, 16'd0, 12'd0, 12'd0, 8'd0);
    send_request(OP_SAMPLE, EXIT_WALL, 16'd0, 12'd600, 12'd1000, 8'd3);
    send_request(OP_SAMPLE, EXIT_WALL, 16'd0, 12'd3000, 12'd1000, 8'd3);
    send_request(OP_START, EXIT_NONE, 16'd0, 12'd0, 12'd0, 8'd0);
    send_request(OP_SAMPLE, EXIT_NONE, 16'd0, 12'd600, 12'd0, 8'd9);
    send_request(OP_START, EXIT_FRONT, 16'd8960, 12'd0, 12'd0, 8'd0);
    send_request(OP_SAMPLE, EXIT_FRONT, 16'd0, 12'd2500, 12'd0, 8'd0);
    send_request(OP_SAMPLE, EXIT_FRONT, 16'd0, 12'd2500, 12'hFFF, 8'd0);

    // long tick run up to the saturation of the tick total
    send_request(OP_START, EXIT_TICKS, 16'hFFFF, 12'd0, 12'd0, 8'd0);
    repeat (262) begin
      send_request(OP_SAMPLE, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                   pick_adc(), pick_adc(), 8'($urandom_range(252, 255)));
      pace();
    end
    run_segments(55);

    drain();
    write_all(16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    run_segments(55);

    drain();
    write_all(16'd0, 16'd0, 20'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_segments(55);

    // floor above ceiling
    drain();
    write_all(16'($urandom_range(2000, 8000)), 16'($urandom_range(0, 8000)),
              20'($urandom_range(0, 200000)), 16'd10000, 16'd40000,
              16'($urandom_range(0, 65535)), 16'($urandom_range(3000, 12000)));
    run_segments(55);

    drain();
    write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              20'($urandom_range(0, 1048575)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
    run_segments(55);

    drain();
    write_all(16'($urandom_range(2000, 8000)), 16'($urandom_range(0, 8000)),
              20'($urandom_range(0, 200000)), 16'($urandom_range(30000, 60000)),
              16'($urandom_range(0, 25000)), 16'($urandom_range(15000, 35000)),
              16'($urandom_range(3000, 12000)));
    run_segments(55);

    drain();
    if (sb.failures == 0 && sb.pending() == 0)
      $display("wall_follow_pd_controller_test: PASS");
    else
      $display("wall_follow_pd_controller_test: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/wfpd_pkg.sv
rtl/core/wfpd_div.sv
rtl/core/wfpd_datapath.sv
rtl/core/wfpd_ctrl.sv
rtl/core/wall_follow_pd_controller.sv
test/wall_follow_pd_controller_test.sv
